FILE: src/shift_and_string_matcher_macros.svh
// ----------------------------------------------------------------------------
// shift_and_string_matcher_macros
// assertion macros shared by the matcher rtl, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef SHIFT_AND_STRING_MATCHER_MACROS_SVH
`define SHIFT_AND_STRING_MATCHER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on the rising clock edge
`define SASM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SASM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SASM_ASSERT_IMPLY(label, ante, cons, msg)

`define SASM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: src/sasm_pkg.sv
// ----------------------------------------------------------------------------
// sasm_pkg
// types and constants shared by the shift-and string matcher modules
// ----------------------------------------------------------------------------
package sasm_pkg;

  // pattern and alphabet sizes
  localparam int MAX_PATTERN = 64;
  localparam int POS_W       = 6;
  localparam int CHAR_W      = 7;
  localparam int LEN_W       = 7;
  localparam int NUM_CHARS   = 128;

  // text code that matches nothing
  localparam logic [CHAR_W-1:0] NO_MATCH_CODE = 7'd127;

  typedef logic [MAX_PATTERN-1:0] vec_t;

  // request codes
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TEXT    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  // load sequencer states
  typedef enum logic [2:0] {
    LD_IDLE = 3'b001,
    LD_SET  = 3'b010,
    LD_CLR  = 3'b100
  } ld_state_t;

  // access to the character mask memory
  typedef struct packed {
    logic              rd_en;
    logic [CHAR_W-1:0] rd_addr;
    logic              wr_en;
    logic [CHAR_W-1:0] wr_addr;
    vec_t              wr_data;
  } mask_req_t;

  // match core status toward the top level
  typedef struct packed {
    logic s1_valid;
    logic s1_adv;
    logic found;
    logic vec_zero;
  } core_stat_t;

endpackage

FILE: src/sasm_mask_mem.sv
// ----------------------------------------------------------------------------
// sasm_mask_mem
// per-character position masks, one 64-bit row per code, registered read,
// with a valid bit per row so an unwritten row reads as all zeros
// ----------------------------------------------------------------------------
module sasm_mask_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  sasm_pkg::mask_req_t req,
  output sasm_pkg::vec_t      rd_data
);
  import sasm_pkg::*;

  vec_t                 mem [NUM_CHARS];
  logic [NUM_CHARS-1:0] row_vld_r;
  vec_t                 rd_q_r;
  logic                 rd_vld_r;

  // storage array, read before write
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  // row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= row_vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

FILE: src/sasm_pat_mem.sv
// ----------------------------------------------------------------------------
// sasm_pat_mem
// pattern character store, written at one position, old value read back
// ----------------------------------------------------------------------------
module sasm_pat_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [sasm_pkg::POS_W-1:0]    addr,
  input  logic [sasm_pkg::CHAR_W-1:0]   wr_data,
  output logic [sasm_pkg::CHAR_W-1:0]   rd_data
);
  import sasm_pkg::*;

  logic [CHAR_W-1:0] mem [MAX_PATTERN];
  logic [CHAR_W-1:0] rd_q_r;

  // write new character, return the one it replaces
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
      rd_q_r    <= mem[addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

FILE: src/sasm_match_core.sv
// ----------------------------------------------------------------------------
// sasm_match_core
// match vector update and output register: shift, set bit 0, and with the
// character mask and the length mask
// ----------------------------------------------------------------------------
module sasm_match_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          text_acc,
  input  logic                          restart_acc,
  input  logic [sasm_pkg::CHAR_W-1:0]   text_char,
  input  sasm_pkg::vec_t                mask_rd,
  input  sasm_pkg::vec_t                len_mask,
  input  logic [sasm_pkg::POS_W-1:0]    top,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_match_here,
  output logic                          out_found,
  output sasm_pkg::core_stat_t          stat
);
  import sasm_pkg::*;

  logic s1_valid_r, s1_valid_nxt;
  logic nomatch_r;
  vec_t vec_r, vec_nxt;
  logic found_r, found_nxt;
  logic out_valid_r, out_valid_nxt;
  logic match_r, found_out_r;

  logic s1_adv;
  vec_t masked;
  logic hit;
  logic found_hit;

  // vector update for the character waiting on its mask
  always_comb begin
    s1_adv    = s1_valid_r & (~out_valid_r | out_ready);
    masked    = {vec_r[MAX_PATTERN-2:0], 1'b1} & (nomatch_r ? '0 : mask_rd) & len_mask;
    hit       = masked[top];
    found_hit = found_r | hit;

    vec_nxt   = vec_r;
    found_nxt = found_r;
    if (s1_adv) begin
      vec_nxt   = masked;
      found_nxt = found_hit;
    end
    // restart comes after any character already in flight
    if (restart_acc) begin
      vec_nxt   = '0;
      found_nxt = 1'b0;
    end
  end

  // stage and output valid
  always_comb begin
    priority if (text_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    priority if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vec_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      vec_r       <= vec_nxt;
      found_r     <= found_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (text_acc) begin
      nomatch_r <= (text_char == NO_MATCH_CODE);
    end
    if (s1_adv) begin
      match_r     <= hit;
      found_out_r <= found_hit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_match_here = match_r;
  assign out_found      = found_out_r;

  assign stat.s1_valid = s1_valid_r;
  assign stat.s1_adv   = s1_adv;
  assign stat.found    = found_r;
  assign stat.vec_zero = (vec_r == '0);

endmodule

FILE: src/shift_and_string_matcher.sv
// ----------------------------------------------------------------------------
// shift_and_string_matcher
// streaming shift-and exact string matcher with a per-character mask memory
// ----------------------------------------------------------------------------
// Text characters flow at one per cycle while the output side keeps up: each
// one reads its 64-bit position mask from the 128-row mask memory into the
// registered mask read, and the match vector update (shift, set bit 0, and
// with mask and length) is applied as the character moves from there into
// the output register, in the same cycle that the next character can be taken.
// A pattern load holds the input not ready through LD_SET and LD_CLR: the
// two read-modify-writes of the single-port-written mask memory, one setting
// the position in the new character's row and one clearing it in the old
// one. Restart and unused codes give no result. Mask rows carry valid bits
// cleared by reset, so no clearing pass is needed; the user must write
// pattern_len only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`include "shift_and_string_matcher_macros.svh"

module shift_and_string_matcher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [sasm_pkg::POS_W-1:0]    in_position,
  input  logic [sasm_pkg::CHAR_W-1:0]   in_character,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_match_here,
  output logic                          out_found,
  input  logic                          cfg_wr_en,
  input  logic [sasm_pkg::LEN_W-1:0]    cfg_wr_data
);
  import sasm_pkg::*;

  ld_state_t ld_state_r, ld_state_nxt;
  logic [POS_W-1:0]  ld_pos_r;
  logic [CHAR_W-1:0] ld_char_r;
  logic [POS_W-1:0]  top_r, top_nxt;
  vec_t              len_mask_r, len_mask_nxt;

  logic              in_acc;
  logic              load_acc;
  logic              text_acc;
  logic              restart_acc;
  mask_req_t         mask_req;
  vec_t              mask_rd;
  logic [CHAR_W-1:0] old_char;
  vec_t              pos_bit;
  core_stat_t        core_st;

  // request decode
  always_comb begin
    in_ready    = (ld_state_r == LD_IDLE) & (~core_st.s1_valid | core_st.s1_adv);
    in_acc      = in_valid & in_ready;
    load_acc    = in_acc & (in_op == OP_LOAD);
    text_acc    = in_acc & (in_op == OP_TEXT);
    restart_acc = in_acc & (in_op == OP_RESTART);
  end

  // load sequencer
  always_comb begin
    ld_state_nxt = ld_state_r;
    unique case (ld_state_r)
      LD_IDLE: if (load_acc) ld_state_nxt = LD_SET;
      LD_SET:  ld_state_nxt = LD_CLR;
      LD_CLR:  ld_state_nxt = LD_IDLE;
      default: ld_state_nxt = LD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_state_r <= LD_IDLE;
    end else begin
      ld_state_r <= ld_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      ld_pos_r  <= in_position;
      ld_char_r <= in_character;
    end
  end

  // mask memory: reads on accept and in LD_SET, writes from the load sequence
  always_comb begin
    pos_bit          = vec_t'(1) << ld_pos_r;
    mask_req.rd_en   = 1'b0;
    mask_req.rd_addr = in_character;
    mask_req.wr_en   = 1'b0;
    mask_req.wr_addr = ld_char_r;
    mask_req.wr_data = mask_rd | pos_bit;
    unique case (ld_state_r)
      LD_IDLE: begin
        mask_req.rd_en = load_acc | text_acc;
      end
      LD_SET: begin
        mask_req.rd_en   = 1'b1;
        mask_req.rd_addr = old_char;
        mask_req.wr_en   = 1'b1;
      end
      LD_CLR: begin
        // same character again keeps its bit
        mask_req.wr_en   = (old_char != ld_char_r);
        mask_req.wr_addr = old_char;
        mask_req.wr_data = mask_rd & ~pos_bit;
      end
      default: begin
        mask_req.rd_en = 1'b0;
      end
    endcase
  end

  // pattern length register, kept as top index and position mask
  always_comb begin
    priority if (cfg_wr_data == '0) begin
      top_nxt = '0;
    end else if (cfg_wr_data > LEN_W'(MAX_PATTERN)) begin
      top_nxt = POS_W'(MAX_PATTERN - 1);
    end else begin
      top_nxt = POS_W'(cfg_wr_data - LEN_W'(1));
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      len_mask_nxt[i] = (POS_W'(i) <= top_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r      <= '0;
      len_mask_r <= vec_t'(1);
    end else if (cfg_wr_en) begin
      top_r      <= top_nxt;
      len_mask_r <= len_mask_nxt;
    end
  end

  sasm_pat_mem u_pat_mem (
    .clk     (clk),
    .wr_en   (load_acc),
    .addr    (in_position),
    .wr_data (in_character),
    .rd_data (old_char)
  );

  sasm_mask_mem u_mask_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mask_req),
    .rd_data (mask_rd)
  );

  sasm_match_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .text_acc       (text_acc),
    .restart_acc    (restart_acc),
    .text_char      (in_character),
    .mask_rd        (mask_rd),
    .len_mask       (len_mask_r),
    .top            (top_r),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_match_here (out_match_here),
    .out_found      (out_found),
    .stat           (core_st)
  );

  // checks
  `SASM_ASSERT_IMPLY(a_load_blocks_input, ld_state_r != LD_IDLE, !in_ready, "input taken during a load")
  `SASM_ASSERT_NEXT(a_restart_clears, restart_acc, !core_st.found && core_st.vec_zero, "restart left match state")
  `SASM_ASSERT_IMPLY(a_match_sets_found, out_valid && out_match_here, out_found, "match without found flag")

endmodule

FILE: verif/shift_and_string_matcher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shift_and_string_matcher_checker
// watches the matcher channels, predicts every text result and compares it
// ----------------------------------------------------------------------------
// Keeps its own copy of the pattern, the prefix-match bits, the sticky found
// bit and the length register. Every accepted text request queues one
// expected result; every accepted result is compared with the oldest one.
// ----------------------------------------------------------------------------
module shift_and_string_matcher_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [sasm_pkg::POS_W-1:0]    in_position,
  input  logic [sasm_pkg::CHAR_W-1:0]   in_character,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_match_here,
  input  logic                          out_found,
  input  logic                          cfg_wr_en,
  input  logic [sasm_pkg::LEN_W-1:0]    cfg_wr_data,
  output int                            fail_count,
  output int                            pending_count,
  output int                            text_total,
  output int                            hit_total
);
  import sasm_pkg::*;

  typedef struct packed {
    logic match_here;
    logic found;
  } verdict_t;

  logic [CHAR_W-1:0] pattern_chars [MAX_PATTERN];
  vec_t              active_prefixes;
  logic              found_sticky;
  logic [LEN_W-1:0]  len_setting;
  verdict_t          expected_verdicts [$];

  int mismatches = 0;
  int texts_seen = 0;
  int hits_seen  = 0;

  assign fail_count = mismatches;
  assign text_total = texts_seen;
  assign hit_total  = hits_seen;

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("[%0t] mismatch on %s: got %0b, expected %0b", $time, what, got, want);
    mismatches++;
  endtask

  // advance the predicted matcher state by one accepted request
  task automatic step_matcher(input logic [1:0] op, input logic [POS_W-1:0] pos,
                              input logic [CHAR_W-1:0] ch);
    int       eff;
    vec_t     char_hits;
    verdict_t v;
    case (op)
      OP_LOAD: begin
        pattern_chars[pos] = ch;
      end
      OP_RESTART: begin
        active_prefixes = '0;
        found_sticky    = 1'b0;
      end
      OP_TEXT: begin
        // zero acts as one, anything past the store acts as the full store
        if (len_setting == 0)
          eff = 1;
        else if (len_setting > MAX_PATTERN)
          eff = MAX_PATTERN;
        else
          eff = len_setting;
        // the no-match code hits no position
        char_hits = '0;
        if (ch != NO_MATCH_CODE) begin
          for (int i = 0; i < eff; i++)
            if (pattern_chars[i] == ch) char_hits[i] = 1'b1;
        end
        active_prefixes = ((active_prefixes << 1) | vec_t'(1)) & char_hits;
        v.match_here = active_prefixes[eff-1];
        if (v.match_here) found_sticky = 1'b1;
        v.found = found_sticky;
        expected_verdicts.push_back(v);
        texts_seen++;
        if (v.match_here) hits_seen++;
      end
      default: begin
        // unused code, ignored
      end
    endcase
  endtask

  // sample both channels and the register port at each edge
  always @(posedge clk) begin : watch_channels
    verdict_t want;
    if (!rst_n) begin
      active_prefixes = '0;
      found_sticky    = 1'b0;
      len_setting     = 7'd1;
      expected_verdicts.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("out_valid with no text request waiting", 1'b1, 1'b0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_match_here !== want.match_here)
            report_mismatch("match_here", out_match_here, want.match_here);
          if (out_found !== want.found)
            report_mismatch("found", out_found, want.found);
        end
      end
      if (in_valid && in_ready)
        step_matcher(in_op, in_position, in_character);
      if (cfg_wr_en)
        len_setting = cfg_wr_data;
    end
    pending_count <= expected_verdicts.size();
  end

endmodule

FILE: verif/tb_shift_and_string_matcher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shift_and_string_matcher
// stimulus and verdict for the shift-and string matcher
// ----------------------------------------------------------------------------
// A short directed run covers the shortest lengths, the no-match code in text
// and pattern, loads during a text stream, restarts and the unused code.
// Random phases then set a length, load a pattern from a small alphabet and
// stream text built mostly from copies of the pattern, with random idling on
// both sides, one long result stall and drains between length settings.
// ----------------------------------------------------------------------------
module tb_shift_and_string_matcher;
  import sasm_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         RANDOM_ITEMS   = 500;
  localparam int         HOLD_CYCLES    = 100;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         BURST_PHASE    = 0;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [1:0]        in_op          = '0;
  logic [POS_W-1:0]  in_position    = '0;
  logic [CHAR_W-1:0] in_character   = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic              out_match_here;
  logic              out_found;
  logic              cfg_wr_en      = 1'b0;
  logic [LEN_W-1:0]  cfg_wr_data    = '0;

  int fail_count;
  int pending_count;
  int text_total;
  int hit_total;

  // stimulus bookkeeping
  int                requests_sent = 0;
  int                directed_sent = 0;
  int                phases_run    = 0;
  int                eff_len       = 1;
  int                alpha_base    = 0;
  int                alpha_span    = 1;
  bit                no_gaps       = 1'b0;
  bit                hold_kick     = 1'b0;
  int                idle_cycles   = 0;
  logic [CHAR_W-1:0] pattern_copy [MAX_PATTERN];

  always #5 clk = ~clk;

  shift_and_string_matcher dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_character   (in_character),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_match_here (out_match_here),
    .out_found      (out_found),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  shift_and_string_matcher_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_character   (in_character),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_match_here (out_match_here),
    .out_found      (out_found),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .text_total     (text_total),
    .hit_total      (hit_total)
  );

  // watchdog: cycles in a row with nothing accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("shift_and_string_matcher verification failed");
        $finish;
      end
    end
  end

  // result side: random stalls, fast stretches, one long hold when kicked
  initial begin : result_sink
    int   gap;
    int   served;
    bit   seen_kick;
    bit   fast;
    served    = 0;
    seen_kick = 1'b0;
    fast      = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_kick != seen_kick) begin
        seen_kick = hold_kick;
        gap = HOLD_CYCLES;
      end else if (fast) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 12);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      served++;
      if (served % 40 == 0) fast = ($urandom_range(0, 2) == 0);
    end
  end

  // one request, after a random gap unless gaps are off
  task automatic send_request(input logic [1:0] op, input logic [POS_W-1:0] pos,
                              input logic [CHAR_W-1:0] ch);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_position  <= pos;
    in_character <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) requests_sent++;
  endtask

  task automatic send_text(input logic [CHAR_W-1:0] ch);
    send_request(OP_TEXT, POS_W'($urandom_range(0, 63)), ch);
  endtask

  // stop offering and wait until every result is back, then let loads settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pattern_len(input logic [LEN_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (value == 0)
      eff_len = 1;
    else if (value > MAX_PATTERN)
      eff_len = MAX_PATTERN;
    else
      eff_len = value;
  endtask

  // character from the phase alphabet, now and then the no-match code
  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(0, 40) == 0) return NO_MATCH_CODE;
    return CHAR_W'((alpha_base + $urandom_range(0, alpha_span)) % 127);
  endfunction

  // one random phase: length, pattern load, then a text stream
  task automatic run_phase(input logic [LEN_W-1:0] len, input int idx);
    int budget;
    int done;
    int r;
    int n;
    int p;
    set_pattern_len(len);
    alpha_base = $urandom_range(0, 126);
    alpha_span = $urandom_range(1, 3);
    no_gaps    = ($urandom_range(0, 3) == 0);
    // every position in use is written before any text
    for (int i = 0; i < eff_len; i++) begin
      pattern_copy[i] = pick_char();
      send_request(OP_LOAD, POS_W'(i), pattern_copy[i]);
    end
    // back-to-back text against a long result stall
    if (idx == BURST_PHASE) begin
      no_gaps   = 1'b1;
      hold_kick = ~hold_kick;
      repeat (40) send_text(pick_char());
      no_gaps = ($urandom_range(0, 1) == 0);
    end
    budget = (eff_len <= 8) ? 40 : 2 * eff_len + 16;
    done = 0;
    while (done < budget) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        // whole pattern or a broken-off prefix
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, eff_len) : eff_len;
        for (int i = 0; i < n; i++) send_text(pattern_copy[i]);
        done += n;
      end else if (r < 80) begin
        send_text(pick_char());
        done++;
      end else if (r < 86) begin
        send_text(CHAR_W'($urandom_range(0, 127)));
        done++;
      end else if (r < 91) begin
        send_request(OP_RESTART, POS_W'($urandom_range(0, 63)),
                     CHAR_W'($urandom_range(0, 127)));
        done++;
      end else if (r < 96) begin
        // load in the middle of the stream
        p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, eff_len - 1);
        pattern_copy[p] = pick_char();
        send_request(OP_LOAD, POS_W'(p), pattern_copy[p]);
        done++;
      end else begin
        send_request(OP_UNUSED, POS_W'($urandom_range(0, 63)),
                     CHAR_W'($urandom_range(0, 127)));
      end
    end
    phases_run++;
  endtask

  // mostly short patterns so matches are frequent, a few long ones
  task automatic r_len_pick(output logic [LEN_W-1:0] len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85)
      len = LEN_W'($urandom_range(2, 8));
    else if (r < 96)
      len = LEN_W'($urandom_range(9, 40));
    else
      len = LEN_W'($urandom_range(41, 127));
  endtask

  // main sequence
  initial begin : stimulus
    logic [LEN_W-1:0] len;
    int               phase;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-character pattern after reset
    send_request(OP_LOAD, 6'd0, 7'd0);
    send_text(7'd0);
    send_text(7'd126);
    send_request(OP_RESTART, 6'd0, 7'd0);
    send_text(NO_MATCH_CODE);
    send_request(OP_LOAD, 6'd63, NO_MATCH_CODE);
    send_request(OP_UNUSED, 6'd63, 7'd127);
    send_text(7'd0);
    // two characters, no-match code stored in the pattern
    set_pattern_len(7'd2);
    send_request(OP_LOAD, 6'd1, NO_MATCH_CODE);
    send_text(7'd0);
    send_text(NO_MATCH_CODE);
    send_request(OP_LOAD, 6'd1, 7'd126);
    send_text(7'd0);
    // a load between text characters leaves the match state alone
    send_request(OP_LOAD, 6'd5, 7'd3);
    send_text(7'd126);
    send_text(7'd64);
    send_request(OP_RESTART, 6'd63, 7'd127);
    send_text(7'd126);
    // zero length acts as one
    set_pattern_len(7'd0);
    send_text(7'd0);
    send_text(7'd126);
    directed_sent = requests_sent;

    // random phases, length extremes first
    phase = 0;
    while (requests_sent - directed_sent < RANDOM_ITEMS) begin
      case (phase)
        0:       len = 7'd1;
        1:       len = 7'd64;
        2:       len = 7'd0;
        3:       len = 7'd127;
        default: begin
          r_len_pick(len);
        end
      endcase
      run_phase(len, phase);
      phase++;
    end

    drain_results();
    $display("%0d requests over %0d random length settings (0, 1, 64 and 127 among them)",
             requests_sent, phases_run);
    $display("%0d text characters checked, %0d of them ending a full match",
             text_total, hit_total);
    if (fail_count == 0) begin
      $display("shift_and_string_matcher verification clean");
    end else begin
      $display("shift_and_string_matcher verification failed");
    end
    $finish;
  end

endmodule
